>>> hw/rtl/m31alu_pkg.sv
package m31alu_pkg;

    // Field parameters
    localparam int          FW       = 31;
    localparam logic [30:0] MODULUS  = 31'h7FFF_FFFF;
    localparam logic [30:0] INV_EXP  = MODULUS - 31'd2;
    localparam int          PW       = 2 * FW;
    localparam int          CNT_W    = 5;
    localparam int          UADDR_W  = 5;

    // Request opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_NEG = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;
    localparam logic [2:0] OP_DOT = 3'd5;

    // Microprogram addresses
    localparam logic [4:0] U_IDLE     = 5'd0;
    localparam logic [4:0] U_ADD      = 5'd1;
    localparam logic [4:0] U_SUB      = 5'd2;
    localparam logic [4:0] U_NEG      = 5'd3;
    localparam logic [4:0] U_MUL      = 5'd4;
    localparam logic [4:0] U_MUL_FOLD = 5'd5;
    localparam logic [4:0] U_DOT      = 5'd6;
    localparam logic [4:0] U_DOT_FOLD = 5'd7;
    localparam logic [4:0] U_DOT_ACC  = 5'd8;
    localparam logic [4:0] U_INV      = 5'd9;
    localparam logic [4:0] U_INV_TEST = 5'd10;
    localparam logic [4:0] U_INV_MUL  = 5'd11;
    localparam logic [4:0] U_INV_MFLD = 5'd12;
    localparam logic [4:0] U_INV_END  = 5'd13;
    localparam logic [4:0] U_INV_SQR  = 5'd14;
    localparam logic [4:0] U_INV_SFLD = 5'd15;
    localparam logic [4:0] U_INV_OUT  = 5'd16;

    // Multiplier operand selects
    localparam logic [1:0] MA_A    = 2'd0;
    localparam logic [1:0] MA_X    = 2'd1;
    localparam logic [1:0] MA_BASE = 2'd2;
    localparam logic       MB_B    = 1'b0;
    localparam logic       MB_BASE = 1'b1;

    // Register write codes
    localparam logic [3:0] WR_NONE = 4'd0;
    localparam logic [3:0] WR_ADD  = 4'd1;
    localparam logic [3:0] WR_SUB  = 4'd2;
    localparam logic [3:0] WR_NEG  = 4'd3;
    localparam logic [3:0] WR_MUL  = 4'd4;
    localparam logic [3:0] WR_DOT  = 4'd5;
    localparam logic [3:0] WR_X    = 4'd6;
    localparam logic [3:0] WR_BASE = 4'd7;
    localparam logic [3:0] WR_INIT = 4'd8;
    localparam logic [3:0] WR_RESX = 4'd9;

    // Sequencer jump codes
    localparam logic [2:0] J_NEXT   = 3'd0;
    localparam logic [2:0] J_IDLE   = 3'd1;
    localparam logic [2:0] J_GOTO   = 3'd2;
    localparam logic [2:0] J_EXPZ   = 3'd3;
    localparam logic [2:0] J_CNTEND = 3'd4;

    typedef struct packed {
        logic       load;
        logic [1:0] a_sel;
        logic       b_sel;
        logic       ld_prod;
        logic [3:0] wr;
        logic       cnt_inc;
    } dp_ctrl_t;

    typedef struct packed {
        logic exp_bit;
        logic cnt_end;
        logic last;
    } dp_stat_t;

    typedef struct packed {
        logic [1:0]         a_sel;
        logic               b_sel;
        logic               ld_prod;
        logic [3:0]         wr;
        logic               cnt_inc;
        logic               emit;
        logic               emit_last;
        logic [2:0]         jmp;
        logic [UADDR_W-1:0] target;
    } uword_t;

    function automatic uword_t mk_uword(
        input logic [1:0]         a_sel,
        input logic               b_sel,
        input logic               ld_prod,
        input logic [3:0]         wr,
        input logic               cnt_inc,
        input logic               emit,
        input logic               emit_last,
        input logic [2:0]         jmp,
        input logic [UADDR_W-1:0] target
    );
        uword_t w;
        w.a_sel     = a_sel;
        w.b_sel     = b_sel;
        w.ld_prod   = ld_prod;
        w.wr        = wr;
        w.cnt_inc   = cnt_inc;
        w.emit      = emit;
        w.emit_last = emit_last;
        w.jmp       = jmp;
        w.target    = target;
        return w;
    endfunction

    // Microprogram store
    function automatic uword_t ucode_rom(input logic [UADDR_W-1:0] addr);
        uword_t w;
        case (addr)
            U_ADD:      w = mk_uword(MA_A, MB_B, 1'b0, WR_ADD, 1'b0, 1'b1, 1'b0, J_IDLE, U_IDLE);
            U_SUB:      w = mk_uword(MA_A, MB_B, 1'b0, WR_SUB, 1'b0, 1'b1, 1'b0, J_IDLE, U_IDLE);
            U_NEG:      w = mk_uword(MA_A, MB_B, 1'b0, WR_NEG, 1'b0, 1'b1, 1'b0, J_IDLE, U_IDLE);
            U_MUL:      w = mk_uword(MA_A, MB_B, 1'b1, WR_NONE, 1'b0, 1'b0, 1'b0, J_NEXT, U_IDLE);
            U_MUL_FOLD: w = mk_uword(MA_A, MB_B, 1'b0, WR_MUL, 1'b0, 1'b1, 1'b0, J_IDLE, U_IDLE);
            U_DOT:      w = mk_uword(MA_A, MB_B, 1'b1, WR_NONE, 1'b0, 1'b0, 1'b0, J_NEXT, U_IDLE);
            U_DOT_FOLD: w = mk_uword(MA_A, MB_B, 1'b0, WR_X, 1'b0, 1'b0, 1'b0, J_NEXT, U_IDLE);
            U_DOT_ACC:  w = mk_uword(MA_A, MB_B, 1'b0, WR_DOT, 1'b0, 1'b0, 1'b1, J_IDLE, U_IDLE);
            U_INV:      w = mk_uword(MA_A, MB_B, 1'b0, WR_INIT, 1'b0, 1'b0, 1'b0, J_NEXT, U_IDLE);
            U_INV_TEST: w = mk_uword(MA_A, MB_B, 1'b0, WR_NONE, 1'b0, 1'b0, 1'b0, J_EXPZ,
                                     U_INV_END);
            U_INV_MUL:  w = mk_uword(MA_X, MB_BASE, 1'b1, WR_NONE, 1'b0, 1'b0, 1'b0, J_NEXT,
                                     U_IDLE);
            U_INV_MFLD: w = mk_uword(MA_A, MB_B, 1'b0, WR_X, 1'b0, 1'b0, 1'b0, J_NEXT, U_IDLE);
            U_INV_END:  w = mk_uword(MA_A, MB_B, 1'b0, WR_NONE, 1'b0, 1'b0, 1'b0, J_CNTEND,
                                     U_INV_OUT);
            U_INV_SQR:  w = mk_uword(MA_BASE, MB_BASE, 1'b1, WR_NONE, 1'b1, 1'b0, 1'b0, J_NEXT,
                                     U_IDLE);
            U_INV_SFLD: w = mk_uword(MA_A, MB_B, 1'b0, WR_BASE, 1'b0, 1'b0, 1'b0, J_GOTO,
                                     U_INV_TEST);
            U_INV_OUT:  w = mk_uword(MA_A, MB_B, 1'b0, WR_RESX, 1'b0, 1'b1, 1'b0, J_IDLE, U_IDLE);
            default:    w = mk_uword(MA_A, MB_B, 1'b0, WR_NONE, 1'b0, 1'b0, 1'b0, J_IDLE, U_IDLE);
        endcase
        return w;
    endfunction

    // Opcode dispatch; unused opcodes stay idle
    function automatic logic [UADDR_W-1:0] entry_point(input logic [2:0] op);
        logic [UADDR_W-1:0] e;
        case (op)
            OP_ADD:  e = U_ADD;
            OP_SUB:  e = U_SUB;
            OP_MUL:  e = U_MUL;
            OP_NEG:  e = U_NEG;
            OP_INV:  e = U_INV;
            OP_DOT:  e = U_DOT;
            default: e = U_IDLE;
        endcase
        return e;
    endfunction

    // All-ones pattern equals the modulus and maps to zero
    function automatic logic [FW-1:0] canon(input logic [FW-1:0] v);
        return (v == MODULUS) ? '0 : v;
    endfunction

    function automatic logic [FW-1:0] fadd(input logic [FW-1:0] x, input logic [FW-1:0] y);
        logic [FW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[FW-1:0];
    endfunction

    function automatic logic [FW-1:0] fsub(input logic [FW-1:0] x, input logic [FW-1:0] y);
        logic [FW:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (d[FW]) begin
            d = d + {1'b0, MODULUS};
        end
        return d[FW-1:0];
    endfunction

    function automatic logic [FW-1:0] fneg(input logic [FW-1:0] x);
        return (x == '0) ? '0 : (MODULUS - x);
    endfunction

    // Double Mersenne fold of a product of two canonical elements
    function automatic logic [FW-1:0] fold(input logic [PW-1:0] p);
        logic [FW:0] first;
        logic [FW:0] r;
        first = {1'b0, p[FW-1:0]} + {1'b0, p[PW-1:FW]};
        r     = {1'b0, first[FW-1:0]} + {{FW{1'b0}}, first[FW]};
        if (r >= {1'b0, MODULUS}) begin
            r = r - {1'b0, MODULUS};
        end
        return r[FW-1:0];
    endfunction

endpackage

>>> hw/rtl/m31alu_dp.sv
module m31alu_dp
    import m31alu_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_ctrl_t      ctrl,
    input  logic [FW-1:0] in_a,
    input  logic [FW-1:0] in_b,
    input  logic          in_last,
    output dp_stat_t      stat,
    output logic [FW-1:0] res_value
);

    logic [FW-1:0]    a_reg, a_next;
    logic [FW-1:0]    b_reg, b_next;
    logic             last_reg, last_next;
    logic [FW-1:0]    x_reg, x_next;
    logic [FW-1:0]    base_reg, base_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [FW-1:0]    dot_reg, dot_next;
    logic [FW-1:0]    mul_a;
    logic [FW-1:0]    mul_b;
    logic [FW-1:0]    folded;
    logic [FW-1:0]    dot_sum;

    // Select multiplier operands
    always_comb begin
        case (ctrl.a_sel)
            MA_X:    mul_a = x_reg;
            MA_BASE: mul_a = base_reg;
            default: mul_a = a_reg;
        endcase
        mul_b = (ctrl.b_sel == MB_BASE) ? base_reg : b_reg;
    end

    assign folded  = fold(prod_reg);
    assign dot_sum = fadd(dot_reg, x_reg);

    // Result value for the current write code
    always_comb begin
        case (ctrl.wr)
            WR_ADD:  res_value = fadd(a_reg, b_reg);
            WR_SUB:  res_value = fsub(a_reg, b_reg);
            WR_NEG:  res_value = fneg(a_reg);
            WR_MUL:  res_value = folded;
            WR_DOT:  res_value = dot_sum;
            WR_RESX: res_value = x_reg;
            default: res_value = '0;
        endcase
    end

    // Next-state logic for working registers
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        last_next = last_reg;
        x_next    = x_reg;
        base_next = base_reg;
        cnt_next  = cnt_reg;
        dot_next  = dot_reg;
        prod_next = prod_reg;
        if (ctrl.load) begin
            a_next    = canon(in_a);
            b_next    = canon(in_b);
            last_next = in_last;
        end
        if (ctrl.ld_prod) begin
            prod_next = {{(PW-FW){1'b0}}, mul_a} * {{(PW-FW){1'b0}}, mul_b};
        end
        if (ctrl.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        case (ctrl.wr)
            WR_X:    x_next    = folded;
            WR_BASE: base_next = folded;
            WR_DOT:  dot_next  = last_reg ? '0 : dot_sum;
            WR_INIT: begin
                x_next    = FW'(1);
                base_next = a_reg;
                cnt_next  = '0;
            end
            default: ;
        endcase
    end

    // Hold the dot accumulator across requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
        end else begin
            dot_reg <= dot_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        last_reg <= last_next;
        x_reg    <= x_next;
        base_reg <= base_next;
        prod_reg <= prod_next;
        cnt_reg  <= cnt_next;
    end

    assign stat.exp_bit = INV_EXP[cnt_reg];
    assign stat.cnt_end = (cnt_reg == CNT_W'(FW - 1));
    assign stat.last    = last_reg;

endmodule

>>> hw/rtl/mersenne31_field_alu_with_dot.sv
// Arithmetic unit over the field of integers modulo 2^31 - 1.
// Requests enter on the s_ stream: opcode, operand_a and operand_b in s_tdata,
// and last_element on s_tlast. Results leave on the m_ stream as a canonical
// 31-bit value in m_tdata. Add, sub, mul, neg and inverse give one result per
// request; a dot step gives a result only when s_tlast is set, and that step
// also clears the running accumulator. Opcodes 6 and 7 are taken and dropped.
// A microprogram drives one 31x31 multiplier, a fold unit and the adders, one
// control word per cycle while no stall holds it. s_tready is high only while
// the sequencer is idle, so one request is worked on at a time. An inverse is
// square-and-multiply over 31 exponent bits, four to six microsteps per bit,
// all sharing the one multiplier. A new request is taken in the cycle after
// the last microstep. The result register lets the next request start while
// a result waits; a microstep that must write a new result holds until
// m_tready frees it.
// Reset (aresetn low, synchronous) empties the result register, returns the
// sequencer to idle and clears the dot accumulator.
module mersenne31_field_alu_with_dot
    import m31alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [2:0] opcode, [33:3] operand_a, [64:34] operand_b, zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] value, zero fill
);

    logic [UADDR_W-1:0] upc_reg, upc_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]      m_value_reg, m_value_next;
    uword_t             uw;
    dp_ctrl_t           ctrl;
    dp_stat_t           stat;
    logic [FW-1:0]      res_value;
    logic               idle;
    logic               accept;
    logic               emit;
    logic               stall;
    logic [UADDR_W-1:0] upc_inc;

    assign uw      = ucode_rom(upc_reg);
    assign idle    = (upc_reg == U_IDLE);
    assign accept  = s_tvalid && idle;
    assign emit    = uw.emit || (uw.emit_last && stat.last);
    assign stall   = emit && m_tvalid_reg && !m_tready;
    assign upc_inc = upc_reg + UADDR_W'(1);

    // Drive the datapath; drop the control word while stalled
    always_comb begin
        ctrl.load    = accept;
        ctrl.a_sel   = uw.a_sel;
        ctrl.b_sel   = uw.b_sel;
        ctrl.ld_prod = uw.ld_prod && !stall;
        ctrl.wr      = stall ? WR_NONE : uw.wr;
        ctrl.cnt_inc = uw.cnt_inc && !stall;
    end

    // Advance the step counter
    always_comb begin
        upc_next = upc_reg;
        if (idle) begin
            if (accept) begin
                upc_next = entry_point(s_tdata[2:0]);
            end
        end else if (!stall) begin
            case (uw.jmp)
                J_NEXT:   upc_next = upc_inc;
                J_GOTO:   upc_next = uw.target;
                J_EXPZ:   upc_next = stat.exp_bit ? upc_inc : uw.target;
                J_CNTEND: upc_next = stat.cnt_end ? uw.target : upc_inc;
                default:  upc_next = U_IDLE;
            endcase
        end
    end

    // Load or release the result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_value_next  = m_value_reg;
        if (emit && !stall) begin
            m_tvalid_next = 1'b1;
            m_value_next  = res_value;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= U_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
    end

    m31alu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_a      (s_tdata[33:3]),
        .in_b      (s_tdata[64:34]),
        .in_last   (s_tlast),
        .stat      (stat),
        .res_value (res_value)
    );

    assign s_tready = idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_value_reg};

endmodule
